// File: design/odc_pkg.sv
// shared types, constants and helpers of the oscillator octave / dac calculator
package odc_pkg;

  localparam int unsigned KW = 17;   // request width, khz
  localparam int unsigned FW = 27;   // frequency width, hz
  localparam int unsigned QW = 12;   // quotient bits, one per divider cell
  localparam int unsigned NW = FW + QW - 2 + 12; // numerator shifter width

  localparam logic [KW-1:0] TOP_KHZ    = KW'(68000);
  localparam logic [31:0]   BASE_HZ    = 32'd1039;
  localparam logic [11:0]   DAC_NUM_HZ = 12'd2078;
  localparam logic [12:0]   DAC_OFFSET = 13'd2048;
  localparam logic [3:0]    OCT_MAX    = 4'd15;
  localparam logic [9:0]    DAC_MAX    = 10'd1023;

  typedef struct packed {
    logic [FW-1:0] rem;
    logic [QW-1:0] divd;
    logic [QW-1:0] quo;
    logic [FW-1:0] freq;
    logic [3:0]    oct;
    logic          zero;
    logic          sat;
  } odc_div_t;

  // lowest request in khz that reaches octave idx
  function automatic logic [KW-1:0] oct_th(input int unsigned idx);
    logic [31:0] hz;
    hz = BASE_HZ << idx;
    return KW'((hz + 32'd999) / 32'd1000);
  endfunction

endpackage

// File: design/odc_front.sv
// front cell: hz product, octave search and divider seed
module odc_front import odc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [KW-1:0] khz_i,
  output logic          valid_o,
  input  logic          ready_i,
  output odc_div_t      data_o
);

  logic     valid_r;
  odc_div_t data_r, data_nxt;
  logic [3:0]    oct;
  logic [NW-1:0] num;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    oct = '0;
    for (int unsigned i = 1; i <= 15; i++) begin
      oct = oct + 4'(khz_i >= oct_th(i));
    end
    num = NW'(DAC_NUM_HZ) << (6'd10 + 6'(oct));
    data_nxt.rem  = FW'(num >> QW);
    data_nxt.divd = num[QW-1:0];
    data_nxt.quo  = '0;
    data_nxt.freq = FW'(khz_i) * FW'(1000);
    data_nxt.oct  = oct;
    data_nxt.zero = (khz_i == '0);
    data_nxt.sat  = (khz_i > TOP_KHZ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: design/odc_div_cell.sv
// divider cell: one restoring step, one quotient bit
module odc_div_cell import odc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_i,
  output logic     ready_o,
  input  odc_div_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output odc_div_t data_o
);

  logic     valid_r;
  odc_div_t data_r, data_nxt;
  logic [FW:0] trial;
  logic        fits;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    data_nxt = data_i;
    trial = {data_i.rem, data_i.divd[QW-1]};
    fits  = trial >= {1'b0, data_i.freq};
    data_nxt.rem  = fits ? FW'(trial - {1'b0, data_i.freq}) : FW'(trial);
    data_nxt.divd = {data_i.divd[QW-2:0], 1'b0};
    data_nxt.quo  = {data_i.quo[QW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: design/odc_back.sv
// back cell: ceiling, dac code, special cases, packing and output register
module odc_back import odc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  output logic       ready_o,
  input  odc_div_t   data_i,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_octave_code,
  output logic [9:0] out_dac_code,
  output logic [7:0] out_cmd_high_byte,
  output logic [7:0] out_cmd_low_byte,
  output logic       out_saturated
);

  logic        valid_r;
  logic [3:0]  oct_r, oct_nxt;
  logic [9:0]  dac_r, dac_nxt;
  logic        sat_r, sat_nxt;
  logic [12:0] q;
  logic [12:0] diff;

  assign ready_o = !valid_r || out_ready;

  always_comb begin
    q    = 13'(data_i.quo) + 13'(data_i.rem != '0);
    diff = DAC_OFFSET - q;
    if (data_i.sat) begin
      oct_nxt = OCT_MAX;
      dac_nxt = DAC_MAX;
      sat_nxt = 1'b1;
    end else if (data_i.zero) begin
      oct_nxt = '0;
      dac_nxt = '0;
      sat_nxt = 1'b0;
    end else begin
      oct_nxt = data_i.oct;
      sat_nxt = 1'b0;
      if (q >= DAC_OFFSET) begin
        dac_nxt = '0;
      end else if (diff > 13'(DAC_MAX)) begin
        dac_nxt = DAC_MAX;
      end else begin
        dac_nxt = diff[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      oct_r <= oct_nxt;
      dac_r <= dac_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_octave_code   = oct_r;
  assign out_dac_code      = dac_r;
  assign out_cmd_high_byte = {oct_r, dac_r[9:6]};
  assign out_cmd_low_byte  = {dac_r[5:0], 2'b00};
  assign out_saturated     = sat_r;

  // quotient of an ordinary request lies within one octave
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && !data_i.zero && !data_i.sat |-> q >= 13'd1025 && q <= 13'd2128)
    else $error("divider quotient out of range");

  // above the lowest octave the quotient never passes the dac offset
  a_quo_upper: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && !data_i.zero && !data_i.sat && data_i.oct != '0 |-> q <= DAC_OFFSET)
    else $error("quotient above offset in upper octave");

  // clamped request gives the top codes
  a_sat_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_octave_code == OCT_MAX && out_dac_code == DAC_MAX)
    else $error("saturated word without top codes");

  // zero request gives all-zero codes
  a_zero_codes: assert property (@(posedge clk) disable iff (!rst_n)
    ready_o && valid_i && data_i.zero && !data_i.sat
    |=> out_octave_code == '0 && out_dac_code == '0 && !out_saturated)
    else $error("zero request with nonzero codes");

endmodule

// File: design/oscillator_octave_dac_calc.sv
// top level: oscillator octave / dac code calculator
// Takes one frequency request word per cycle while in_ready is high and returns one result
// word per request, in order, through the front cell (khz to hz product and octave search),
// a chain of twelve divider cells that each settle one bit of the dac quotient, and the
// output register. Every cell holds its word only until the next cell takes it, so bubbles
// close up under a stall and in_ready stays high while any cell, the output register
// included, is free or out_ready is high.
module oscillator_octave_dac_calc import odc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [KW-1:0] in_freq_khz,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_octave_code,
  output logic [9:0]    out_dac_code,
  output logic [7:0]    out_cmd_high_byte,
  output logic [7:0]    out_cmd_low_byte,
  output logic          out_saturated
);

  logic     chain_valid [QW+1];
  logic     chain_ready [QW+1];
  odc_div_t chain_data  [QW+1];

  odc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .khz_i   (in_freq_khz),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    odc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  odc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .valid_i           (chain_valid[QW]),
    .ready_o           (chain_ready[QW]),
    .data_i            (chain_data[QW]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_octave_code   (out_octave_code),
    .out_dac_code      (out_dac_code),
    .out_cmd_high_byte (out_cmd_high_byte),
    .out_cmd_low_byte  (out_cmd_low_byte),
    .out_saturated     (out_saturated)
  );

endmodule
